### hw/rtl/fbl_pkg.sv
package fbl_pkg;

   localparam int GRID_SIZE_DEF = 25;
   localparam int MAX_GRID      = 32;
   localparam int TYPE_W        = 4;
   localparam int COORD_IN_W    = 7;
   localparam int COORD_W       = 9;
   localparam int DELTA_W       = 8;
   localparam int ACC_W         = 9;
   localparam int ROW_DATA_W    = 25;
   localparam int REQ_TDATA_W   = 56;
   localparam int RSP_TDATA_W   = 32;

   typedef enum logic [TYPE_W-1:0] {
      REQ_WR_PIXEL = 4'd0,
      REQ_WR_ROW   = 4'd1,
      REQ_OR_ROW   = 4'd2,
      REQ_RD_PIXEL = 4'd3,
      REQ_RD_ROW   = 4'd4,
      REQ_CLEAR    = 4'd5,
      REQ_LINE     = 4'd6,
      REQ_MOVE     = 4'd7,
      REQ_LINE_TO  = 4'd8
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_CALC,
      ST_PLOT,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic start;
      logic calc;
      logic adv;
   } line_ctl_type;

   typedef struct packed {
      logic                       skip;
      logic                       next_ok;
      logic signed [COORD_W-1:0]  next_y;
      logic                       plot_ok;
      logic signed [COORD_W-1:0]  plot_x;
      logic signed [COORD_W-1:0]  plot_y;
      logic                       last;
   } line_sts_type;

   typedef struct packed {
      logic [ROW_DATA_W-1:0] row_word;
      logic                  point_on;
      logic                  coord_error;
   } result_type;

endpackage

### hw/rtl/mono_framebuffer_line_engine.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  req_tuser: command; req_tdata: operands
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: row word, pixel, error
//
// Write row, clear, move, ignored codes, skipped lines and off-grid pixel or row
// commands go straight to ST_RESP; in-grid pixel and row read/modify commands pass
// ST_ACCESS first. A line runs ST_CALC then ST_PLOT per step (row read, then write
// back), up to major delta + 1 steps, GRID_SIZE at most when its lower end lies on
// the grid. Reset clears the store at once through per-row valid flags. A new
// transaction is taken while a result waits in rsp; a full rsp register holds it.
module mono_framebuffer_line_engine #(
   parameter int GRID_SIZE = fbl_pkg::GRID_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_type[3:0]
   input  logic [fbl_pkg::TYPE_W-1:0]      req_tuser,
   // x_a[6:0], y_a[13:7], x_b[20:14], y_b[27:21],
   // pixel_value[28], row_data[53:29], zero fill
   input  logic [fbl_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // row_word[24:0], point_on[25], coord_error[26], zero fill
   output logic [fbl_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(GRID_SIZE);

   logic [fbl_pkg::TYPE_W-1:0]            req_type;
   logic signed [fbl_pkg::COORD_IN_W-1:0] x_a, y_a, x_b, y_b;
   logic                                  pixel_value;
   logic [fbl_pkg::ROW_DATA_W-1:0]        row_data;

   fbl_pkg::line_ctl_type                 line_ctl;
   fbl_pkg::line_sts_type                 line_sts;
   logic signed [fbl_pkg::COORD_IN_W-1:0] line_x1, line_y1, line_x2, line_y2;

   logic                 mem_clear, mem_rd_en, mem_wr_en;
   logic [AW-1:0]        mem_rd_addr, mem_wr_addr;
   logic [GRID_SIZE-1:0] mem_rd_data, mem_wr_data;

   logic                            res_valid, res_ready;
   fbl_pkg::result_type             res;
   logic                            rsp_tvalid_ff, rsp_tvalid_in;
   logic [fbl_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   assign req_type    = req_tuser;
   assign x_a         = req_tdata[6:0];
   assign y_a         = req_tdata[13:7];
   assign x_b         = req_tdata[20:14];
   assign y_b         = req_tdata[27:21];
   assign pixel_value = req_tdata[28];
   assign row_data    = req_tdata[53:29];

   fbl_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_type    (req_type),
      .x_a         (x_a),
      .y_a         (y_a),
      .x_b         (x_b),
      .y_b         (y_b),
      .pixel_value (pixel_value),
      .row_data    (row_data),
      .line_ctl    (line_ctl),
      .line_sts    (line_sts),
      .line_x1     (line_x1),
      .line_y1     (line_y1),
      .line_x2     (line_x2),
      .line_y2     (line_y2),
      .mem_clear   (mem_clear),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   fbl_line #(.GRID_SIZE(GRID_SIZE)) u_line (
      .clock (clock),
      .ctl   (line_ctl),
      .x1    (line_x1),
      .y1    (line_y1),
      .x2    (line_x2),
      .y2    (line_y2),
      .sts   (line_sts)
   );

   fbl_mem #(.GRID_SIZE(GRID_SIZE)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (mem_clear),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // output register: load a finished result whenever the slot frees up
   always_comb begin
      res_ready     = !rsp_tvalid_ff || rsp_tready;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (res_valid && res_ready) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = fbl_pkg::RSP_TDATA_W'({res.coord_error, res.point_on, res.row_word});
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### hw/rtl/fbl_mem.sv
module fbl_mem #(
   parameter int GRID_SIZE = fbl_pkg::GRID_SIZE_DEF,
   localparam int AW = $clog2(GRID_SIZE)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [GRID_SIZE-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [GRID_SIZE-1:0] wr_data
);

   logic [GRID_SIZE-1:0] rows [GRID_SIZE];
   logic [GRID_SIZE-1:0] valid_ff;
   logic [GRID_SIZE-1:0] valid_in;
   logic [GRID_SIZE-1:0] q_ff;
   logic                 q_valid_ff;

   // a row never written since reset or the last clear reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (clear) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff       <= rows[rd_addr];
         q_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = q_valid_ff ? q_ff : '0;

endmodule

### hw/rtl/fbl_line.sv
module fbl_line #(
   parameter int GRID_SIZE = fbl_pkg::GRID_SIZE_DEF
) (
   input  logic                                   clock,
   input  fbl_pkg::line_ctl_type                  ctl,
   input  logic signed [fbl_pkg::COORD_IN_W-1:0]  x1,
   input  logic signed [fbl_pkg::COORD_IN_W-1:0]  y1,
   input  logic signed [fbl_pkg::COORD_IN_W-1:0]  x2,
   input  logic signed [fbl_pkg::COORD_IN_W-1:0]  y2,
   output fbl_pkg::line_sts_type                  sts
);

   localparam int CW = fbl_pkg::COORD_W;
   localparam int DW = fbl_pkg::DELTA_W;
   localparam int AC = fbl_pkg::ACC_W;
   localparam logic signed [CW-1:0] GRID_S = CW'(GRID_SIZE);
   localparam logic signed [CW-1:0] ONE_S  = CW'(1);

   logic signed [CW-1:0] ex1, ey1, ex2, ey2, ddx, ddy;
   logic [DW-1:0]        dx, dy;
   logic                 major_x;

   logic                 major_x_ff, up_ff;
   logic signed [CW-1:0] maj_ff, min_ff, maj_in, min_in;
   logic [AC-1:0]        acc_ff, acc_in, acc_sum;
   logic [DW-1:0]        dmaj_ff, dmin_ff, cnt_ff, cnt_in;
   logic                 up_in;
   logic                 over;
   logic signed [CW-1:0] step_min, maj_p1;
   logic signed [CW-1:0] px_ff, py_ff, px_in, py_in;

   always_comb begin
      ex1 = CW'(x1);
      ey1 = CW'(y1);
      ex2 = CW'(x2);
      ey2 = CW'(y2);
      ddx = ex1 - ex2;
      ddy = ey1 - ey2;
      dx  = ddx < 0 ? DW'(-ddx) : DW'(ddx);
      dy  = ddy < 0 ? DW'(-ddy) : DW'(ddy);
      major_x = dx > dy;
   end

   // error accumulator step, one per calc pulse
   always_comb begin
      acc_sum  = acc_ff + AC'(dmin_ff);
      over     = acc_sum > AC'(dmaj_ff);
      step_min = up_ff ? min_ff + ONE_S : min_ff - ONE_S;
      maj_p1   = maj_ff + ONE_S;
   end

   always_comb begin
      maj_in = maj_ff;
      min_in = min_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      up_in  = up_ff;
      if (ctl.start) begin
         acc_in = '0;
         if (major_x) begin
            cnt_in = dx;
            if (ex2 > ex1) begin
               maj_in = ex1;
               min_in = ey1;
               up_in  = ey2 > ey1;
            end else begin
               maj_in = ex2;
               min_in = ey2;
               up_in  = ey1 > ey2;
            end
         end else begin
            cnt_in = dy;
            if (ey2 > ey1) begin
               maj_in = ey1;
               min_in = ex1;
               up_in  = ex2 > ex1;
            end else begin
               maj_in = ey2;
               min_in = ex2;
               up_in  = ex1 > ex2;
            end
         end
      end else if (ctl.calc) begin
         acc_in = over ? acc_sum - AC'(dmaj_ff) : acc_sum;
         min_in = over ? step_min : min_ff;
      end else if (ctl.adv) begin
         maj_in = maj_p1;
         cnt_in = cnt_ff - DW'(1);
      end
   end

   // plot point as it stands after the calc pulse
   always_comb begin
      px_in = major_x_ff ? maj_ff : min_in;
      py_in = major_x_ff ? min_in : maj_ff;
      if (!ctl.calc) begin
         px_in = px_ff;
         py_in = py_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         major_x_ff <= major_x;
         dmaj_ff    <= major_x ? dx : dy;
         dmin_ff    <= major_x ? dy : dx;
      end
      maj_ff <= maj_in;
      min_ff <= min_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      up_ff  <= up_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
   end

   always_comb begin
      sts.skip    = ((ex1 >= GRID_S) && (ex2 >= GRID_S)) ||
                    ((ey1 >= GRID_S) && (ey2 >= GRID_S));
      sts.next_y  = major_x_ff ? (over ? step_min : min_ff) : maj_ff;
      sts.next_ok = (sts.next_y >= 0) && (sts.next_y < GRID_S);
      sts.plot_x  = px_ff;
      sts.plot_y  = py_ff;
      sts.plot_ok = (px_ff >= 0) && (px_ff < GRID_S) && (py_ff >= 0) && (py_ff < GRID_S);
      sts.last    = (cnt_ff == '0) || (maj_p1 >= GRID_S);
   end

endmodule

### hw/rtl/fbl_ctrl.sv
module fbl_ctrl #(
   parameter int GRID_SIZE = fbl_pkg::GRID_SIZE_DEF,
   localparam int AW = $clog2(GRID_SIZE)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [fbl_pkg::TYPE_W-1:0]             req_type,
   input  logic signed [fbl_pkg::COORD_IN_W-1:0]  x_a,
   input  logic signed [fbl_pkg::COORD_IN_W-1:0]  y_a,
   input  logic signed [fbl_pkg::COORD_IN_W-1:0]  x_b,
   input  logic signed [fbl_pkg::COORD_IN_W-1:0]  y_b,
   input  logic                                   pixel_value,
   input  logic [fbl_pkg::ROW_DATA_W-1:0]         row_data,
   output fbl_pkg::line_ctl_type                  line_ctl,
   input  fbl_pkg::line_sts_type                  line_sts,
   output logic signed [fbl_pkg::COORD_IN_W-1:0]  line_x1,
   output logic signed [fbl_pkg::COORD_IN_W-1:0]  line_y1,
   output logic signed [fbl_pkg::COORD_IN_W-1:0]  line_x2,
   output logic signed [fbl_pkg::COORD_IN_W-1:0]  line_y2,
   output logic                                   mem_clear,
   output logic                                   mem_rd_en,
   output logic [AW-1:0]                          mem_rd_addr,
   input  logic [GRID_SIZE-1:0]                   mem_rd_data,
   output logic                                   mem_wr_en,
   output logic [AW-1:0]                          mem_wr_addr,
   output logic [GRID_SIZE-1:0]                   mem_wr_data,
   output logic                                   res_valid,
   input  logic                                   res_ready,
   output fbl_pkg::result_type                    res
);

   localparam int CW = fbl_pkg::COORD_W;
   localparam int MG = fbl_pkg::MAX_GRID;
   localparam logic signed [CW-1:0] GRID_S = CW'(GRID_SIZE);

   fbl_pkg::ctrl_state_type state_ff, state_in;

   logic [fbl_pkg::TYPE_W-1:0]            op_ff, op_in;
   logic [AW-1:0]                         row_ff, row_in, col_ff, col_in;
   logic                                  pv_ff, pv_in;
   logic [GRID_SIZE-1:0]                  rd_ff, rd_in;
   logic signed [fbl_pkg::COORD_IN_W-1:0] cursor_x_ff, cursor_x_in;
   logic signed [fbl_pkg::COORD_IN_W-1:0] cursor_y_ff, cursor_y_in;
   fbl_pkg::result_type                   res_ff, res_in;

   logic                 accept;
   logic signed [CW-1:0] xa_s, ya_s;
   logic                 xa_ok, ya_ok;
   logic [GRID_SIZE-1:0] row_fit;
   logic [GRID_SIZE-1:0] col_mask, plot_mask;

   always_comb begin
      accept  = (state_ff == fbl_pkg::ST_IDLE) && req_valid;
      xa_s    = CW'(x_a);
      ya_s    = CW'(y_a);
      xa_ok   = (xa_s >= 0) && (xa_s < GRID_S);
      ya_ok   = (ya_s >= 0) && (ya_s < GRID_S);
      // drop row bits beyond the grid, zero-fill a wider grid
      row_fit = GRID_SIZE'(MG'(row_data));
      col_mask  = GRID_SIZE'(1) << col_ff;
      plot_mask = GRID_SIZE'(1) << line_sts.plot_x[AW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbl_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  fbl_pkg::REQ_WR_PIXEL, fbl_pkg::REQ_RD_PIXEL: begin
                     state_in = (xa_ok && ya_ok) ? fbl_pkg::ST_ACCESS : fbl_pkg::ST_RESP;
                  end
                  fbl_pkg::REQ_OR_ROW, fbl_pkg::REQ_RD_ROW: begin
                     state_in = ya_ok ? fbl_pkg::ST_ACCESS : fbl_pkg::ST_RESP;
                  end
                  fbl_pkg::REQ_LINE, fbl_pkg::REQ_LINE_TO: begin
                     state_in = line_sts.skip ? fbl_pkg::ST_RESP : fbl_pkg::ST_CALC;
                  end
                  default: state_in = fbl_pkg::ST_RESP;
               endcase
            end
         end
         fbl_pkg::ST_ACCESS: state_in = fbl_pkg::ST_RESP;
         fbl_pkg::ST_CALC:   state_in = fbl_pkg::ST_PLOT;
         fbl_pkg::ST_PLOT:   state_in = line_sts.last ? fbl_pkg::ST_RESP : fbl_pkg::ST_CALC;
         fbl_pkg::ST_RESP:   state_in = res_ready ? fbl_pkg::ST_IDLE : fbl_pkg::ST_RESP;
         default:            state_in = fbl_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = state_ff == fbl_pkg::ST_IDLE;
      res_valid   = state_ff == fbl_pkg::ST_RESP;
      res         = res_ff;
      line_ctl    = '0;
      line_x1     = x_a;
      line_y1     = y_a;
      line_x2     = x_b;
      line_y2     = y_b;
      mem_clear   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = y_a[AW-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_addr = row_ff;
      mem_wr_data = mem_rd_data;
      case (state_ff)
         fbl_pkg::ST_IDLE: begin
            if (req_type == fbl_pkg::REQ_LINE_TO) begin
               line_x1 = cursor_x_ff;
               line_y1 = cursor_y_ff;
               line_x2 = x_a;
               line_y2 = y_a;
            end
            if (accept) begin
               case (req_type)
                  fbl_pkg::REQ_WR_PIXEL, fbl_pkg::REQ_RD_PIXEL: begin
                     mem_rd_en = xa_ok && ya_ok;
                  end
                  fbl_pkg::REQ_OR_ROW, fbl_pkg::REQ_RD_ROW: begin
                     mem_rd_en = ya_ok;
                  end
                  fbl_pkg::REQ_WR_ROW: begin
                     mem_wr_en   = ya_ok;
                     mem_wr_addr = y_a[AW-1:0];
                     mem_wr_data = row_fit;
                  end
                  fbl_pkg::REQ_CLEAR: mem_clear = 1'b1;
                  fbl_pkg::REQ_LINE, fbl_pkg::REQ_LINE_TO: line_ctl.start = 1'b1;
                  default: ;
               endcase
            end
         end
         fbl_pkg::ST_ACCESS: begin
            case (op_ff)
               fbl_pkg::REQ_WR_PIXEL: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = pv_ff ? (mem_rd_data | col_mask) : (mem_rd_data & ~col_mask);
               end
               fbl_pkg::REQ_OR_ROW: begin
                  mem_wr_en   = 1'b1;
                  mem_wr_data = mem_rd_data | rd_ff;
               end
               default: ;
            endcase
         end
         fbl_pkg::ST_CALC: begin
            line_ctl.calc = 1'b1;
            mem_rd_en     = line_sts.next_ok;
            mem_rd_addr   = line_sts.next_y[AW-1:0];
         end
         fbl_pkg::ST_PLOT: begin
            line_ctl.adv = 1'b1;
            mem_wr_en    = line_sts.plot_ok;
            mem_wr_addr  = line_sts.plot_y[AW-1:0];
            mem_wr_data  = mem_rd_data | plot_mask;
         end
         default: ;
      endcase
   end

   // request and result registers
   always_comb begin
      op_in       = op_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      pv_in       = pv_ff;
      rd_in       = rd_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      res_in      = res_ff;
      if (accept) begin
         op_in  = req_type;
         row_in = y_a[AW-1:0];
         col_in = x_a[AW-1:0];
         pv_in  = pixel_value;
         rd_in  = row_fit;
         res_in = '0;
         case (req_type)
            fbl_pkg::REQ_WR_PIXEL, fbl_pkg::REQ_RD_PIXEL: begin
               res_in.coord_error = !(xa_ok && ya_ok);
            end
            fbl_pkg::REQ_WR_ROW, fbl_pkg::REQ_OR_ROW, fbl_pkg::REQ_RD_ROW: begin
               res_in.coord_error = !ya_ok;
            end
            fbl_pkg::REQ_MOVE, fbl_pkg::REQ_LINE_TO: begin
               cursor_x_in = x_a;
               cursor_y_in = y_a;
            end
            default: ;
         endcase
      end else if (state_ff == fbl_pkg::ST_ACCESS) begin
         case (op_ff)
            fbl_pkg::REQ_RD_PIXEL: res_in.point_on = mem_rd_data[col_ff];
            fbl_pkg::REQ_RD_ROW:   res_in.row_word = fbl_pkg::ROW_DATA_W'(MG'(mem_rd_data));
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= fbl_pkg::ST_IDLE;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      row_ff <= row_in;
      col_ff <= col_in;
      pv_ff  <= pv_in;
      rd_ff  <= rd_in;
      res_ff <= res_in;
   end

endmodule

### verif/tb_mono_framebuffer_line_engine.sv
module tb_mono_framebuffer_line_engine;

   localparam int GRID        = fbl_pkg::GRID_SIZE_DEF;
   localparam int ROW_W       = fbl_pkg::ROW_DATA_W;
   localparam int CIN_W       = fbl_pkg::COORD_IN_W;
   localparam int TUSER_W     = fbl_pkg::TYPE_W;
   localparam int TDATA_W     = fbl_pkg::REQ_TDATA_W;
   localparam int RDATA_W     = fbl_pkg::RSP_TDATA_W;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_CYCLES = 600;
   localparam int RANDOM_ITEMS = 1000;
   localparam int TAIL_ITEMS  = 150;

   // one command as {req_tdata, req_tuser}, lowest field last
   typedef struct packed {
      logic [ROW_W-1:0]            row_data;
      logic                        pixel_value;
      logic signed [CIN_W-1:0]     y_b;
      logic signed [CIN_W-1:0]     x_b;
      logic signed [CIN_W-1:0]     y_a;
      logic signed [CIN_W-1:0]     x_a;
      fbl_pkg::req_code_type       kind;
   } fb_command_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [TUSER_W-1:0]     req_tuser;
   logic [TDATA_W-1:0]     req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RDATA_W-1:0]     rsp_tdata;

   logic hold_rsp      = 1'b0;
   logic no_idle_tail  = 1'b0;
   int   cycle_count   = 0;

   // Shadow copy of the framebuffer and cursor, plus the results still owed.
   class framebuffer_shadow;
      logic [GRID-1:0]         rows [GRID];
      logic [CIN_W-1:0]        cur_x;
      logic [CIN_W-1:0]        cur_y;
      fbl_pkg::result_type     expected_results[$];
      int                      mismatch_count;

      function new();
         foreach (rows[i]) rows[i] = '0;
         cur_x = '0;
         cur_y = '0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function bit on_grid(int v);
         return v >= 0 && v < GRID;
      endfunction

      function void set_dot(int x, int y);
         if (on_grid(x) && on_grid(y)) rows[y][x] = 1'b1;
      endfunction

      // error-accumulator line, walked along the major axis from the lower end
      function void trace_line(int x1, int y1, int x2, int y2);
         int dx, dy, px, py, ex, ey, stp, acc, i;
         if ((x1 >= GRID && x2 >= GRID) || (y1 >= GRID && y2 >= GRID)) return;
         dx  = x1 > x2 ? x1 - x2 : x2 - x1;
         dy  = y1 > y2 ? y1 - y2 : y2 - y1;
         acc = 0;
         if (dx > dy) begin
            if (x2 > x1) begin
               px = x1; py = y1; ey = y2;
            end else begin
               px = x2; py = y2; ey = y1;
            end
            stp = ey > py ? 1 : -1;
            for (i = 0; i <= dx; i++) begin
               acc += dy;
               if (acc > dx) begin
                  acc -= dx;
                  py  += stp;
               end
               set_dot(px, py);
               px++;
               if (px >= GRID) break;
            end
         end else begin
            if (y2 > y1) begin
               px = x1; py = y1; ex = x2;
            end else begin
               px = x2; py = y2; ex = x1;
            end
            stp = ex > px ? 1 : -1;
            for (i = 0; i <= dy; i++) begin
               acc += dx;
               if (acc > dy) begin
                  acc -= dy;
                  px  += stp;
               end
               set_dot(px, py);
               py++;
               if (py >= GRID) break;
            end
         end
      endfunction

      function void apply_command(logic [TDATA_W+TUSER_W-1:0] d);
         fb_command_type      c;
         fbl_pkg::result_type r;
         int                  xa, ya;
         c  = fb_command_type'(d[$bits(fb_command_type)-1:0]);
         r  = '0;
         xa = $signed(c.x_a);
         ya = $signed(c.y_a);
         case (c.kind)
            fbl_pkg::REQ_WR_PIXEL, fbl_pkg::REQ_RD_PIXEL: begin
               if (!on_grid(xa) || !on_grid(ya)) r.coord_error = 1'b1;
               else if (c.kind == fbl_pkg::REQ_WR_PIXEL) rows[ya][xa] = c.pixel_value;
               else r.point_on = rows[ya][xa];
            end
            fbl_pkg::REQ_WR_ROW, fbl_pkg::REQ_OR_ROW, fbl_pkg::REQ_RD_ROW: begin
               if (!on_grid(ya)) r.coord_error = 1'b1;
               else if (c.kind == fbl_pkg::REQ_WR_ROW) rows[ya] = c.row_data[GRID-1:0];
               else if (c.kind == fbl_pkg::REQ_OR_ROW) rows[ya] |= c.row_data[GRID-1:0];
               else r.row_word = ROW_W'(rows[ya]);
            end
            fbl_pkg::REQ_CLEAR: begin
               foreach (rows[i]) rows[i] = '0;
            end
            fbl_pkg::REQ_LINE: begin
               trace_line(xa, ya, $signed(c.x_b), $signed(c.y_b));
            end
            fbl_pkg::REQ_MOVE: begin
               cur_x = c.x_a;
               cur_y = c.y_a;
            end
            fbl_pkg::REQ_LINE_TO: begin
               trace_line($signed(cur_x), $signed(cur_y), xa, ya);
               cur_x = c.x_a;
               cur_y = c.y_a;
            end
            default: ;
         endcase
         expected_results.push_back(r);
      endfunction

      task report(string what, int got, int want);
         if (mismatch_count < 100)
            $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
         mismatch_count++;
      endtask

      task check_result(logic [RDATA_W-1:0] d);
         fbl_pkg::result_type want;
         if (expected_results.size() == 0) begin
            report("result with no command outstanding", d, 0);
         end else begin
            want = expected_results.pop_front();
            if (d[ROW_W-1:0] != want.row_word)
               report("row_word", d[ROW_W-1:0], want.row_word);
            if (d[ROW_W] != want.point_on)
               report("point_on", d[ROW_W], want.point_on);
            if (d[ROW_W+1] != want.coord_error)
               report("coord_error", d[ROW_W+1], want.coord_error);
         end
      endtask
   endclass

   framebuffer_shadow shadow = new();

   mono_framebuffer_line_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) shadow.apply_command({req_tdata, req_tuser});
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_result(rsp_tdata);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: random stall bursts, one long hold-off, steady at the tail
   initial begin
      int n;
      rsp_tready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (no_idle_tail) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            case ($urandom_range(7))
               0, 1, 2: begin
                  rsp_tready <= 1'b0;
                  n = $urandom_range(11, 1);
               end
               3: begin
                  rsp_tready <= 1'b1;
                  n = $urandom_range(80, 30);
               end
               default: begin
                  rsp_tready <= 1'b1;
                  n = $urandom_range(11, 1);
               end
            endcase
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_cmd(input fb_command_type c, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= c.kind;
      req_tdata  <= {{(TDATA_W + TUSER_W - $bits(fb_command_type)){1'b0}},
                     c[$bits(fb_command_type)-1:TUSER_W]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic issue(input fbl_pkg::req_code_type k, input int xa, input int ya,
                        input int xb, input int yb, input logic pv,
                        input logic [ROW_W-1:0] rd);
      fb_command_type c;
      c.kind        = k;
      c.x_a         = CIN_W'(xa);
      c.y_a         = CIN_W'(ya);
      c.x_b         = CIN_W'(xb);
      c.y_b         = CIN_W'(yb);
      c.pixel_value = pv;
      c.row_data    = rd;
      send_cmd(c, 0);
   endtask

   // mostly near the grid, sometimes anywhere in the signed range
   function automatic logic signed [CIN_W-1:0] pick_coord();
      int t;
      if ($urandom_range(4) == 0) t = $urandom_range(127);
      else t = int'($urandom_range(30)) - 3;
      return CIN_W'(t);
   endfunction

   function automatic fb_command_type random_command();
      fb_command_type c;
      int             w;
      c.x_a         = pick_coord();
      c.y_a         = pick_coord();
      c.x_b         = $urandom_range(3) == 0 ? CIN_W'($urandom) : pick_coord();
      c.y_b         = $urandom_range(3) == 0 ? CIN_W'($urandom) : pick_coord();
      c.pixel_value = 1'($urandom_range(1));
      case ($urandom_range(3))
         0:       c.row_data = '1;
         1:       c.row_data = ROW_W'(1) << $urandom_range(ROW_W - 1);
         default: c.row_data = ROW_W'($urandom);
      endcase
      w = $urandom_range(99);
      if      (w < 12) c.kind = fbl_pkg::REQ_WR_PIXEL;
      else if (w < 18) c.kind = fbl_pkg::REQ_WR_ROW;
      else if (w < 24) c.kind = fbl_pkg::REQ_OR_ROW;
      else if (w < 38) c.kind = fbl_pkg::REQ_RD_PIXEL;
      else if (w < 56) c.kind = fbl_pkg::REQ_RD_ROW;
      else if (w < 58) c.kind = fbl_pkg::REQ_CLEAR;
      else if (w < 74) c.kind = fbl_pkg::REQ_LINE;
      else if (w < 81) c.kind = fbl_pkg::REQ_MOVE;
      else if (w < 95) c.kind = fbl_pkg::REQ_LINE_TO;
      else c.kind = fbl_pkg::req_code_type'(TUSER_W'($urandom_range(15, 9)));
      return c;
   endfunction

   initial begin
      bit gaps_on;
      int gap;
      int burst_free;
      req_tvalid = 1'b0;
      req_tuser  = '0;
      req_tdata  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // store comes up clear
      issue(fbl_pkg::REQ_RD_PIXEL, 0, 0, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_WR_ROW, 0, 0, -64, 63, 1'b1, '1);
      issue(fbl_pkg::REQ_RD_ROW, 24, 0, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_WR_ROW, 0, 24, 0, 0, 1'b0, 25'h0AA_5533);
      issue(fbl_pkg::REQ_OR_ROW, 0, 24, 0, 0, 1'b0, 25'h155_0001);
      issue(fbl_pkg::REQ_WR_PIXEL, 24, 24, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_RD_ROW, 0, 24, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_WR_PIXEL, 0, 12, 0, 0, 1'b1, '0);
      issue(fbl_pkg::REQ_RD_PIXEL, 0, 12, 0, 0, 1'b0, '0);
      // off-grid pixel and row commands flag an error and leave the store alone
      issue(fbl_pkg::REQ_WR_PIXEL, 25, 0, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_RD_PIXEL, -1, 63, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_WR_ROW, 63, 25, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_OR_ROW, 0, -64, 0, 0, 1'b0, '1);
      issue(fbl_pkg::REQ_RD_ROW, -64, 0, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_CLEAR, 0, 0, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_LINE, 0, 0, 24, 24, 1'b0, '0);
      issue(fbl_pkg::REQ_LINE, 3, -64, 10, 63, 1'b0, '0);
      issue(fbl_pkg::REQ_LINE, 24, 5, -64, 5, 1'b0, '0);
      // both ends past the grid on one axis: nothing drawn
      issue(fbl_pkg::REQ_LINE, 30, 0, 40, 5, 1'b0, '0);
      issue(fbl_pkg::REQ_LINE, 0, 63, 9, 25, 1'b0, '0);
      issue(fbl_pkg::REQ_MOVE, 10, 10, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_LINE_TO, 20, 3, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_MOVE, -64, -64, 0, 0, 1'b0, '0);
      issue(fbl_pkg::REQ_LINE_TO, 63, 63, 0, 0, 1'b0, '0);
      issue(fbl_pkg::req_code_type'(TUSER_W'(15)), 7, 7, 0, 0, 1'b1, '1);

      gaps_on    = 1'b1;
      burst_free = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) gaps_on = $urandom_range(2) != 0;
         if (i == 300) begin
            // stall the result side and keep offering so the input backs up
            hold_rsp   = 1'b1;
            burst_free = 16;
         end
         if (i == RANDOM_ITEMS - TAIL_ITEMS) no_idle_tail = 1'b1;
         gap = 0;
         if (burst_free > 0) burst_free--;
         else if (!no_idle_tail && gaps_on && $urandom_range(2) == 0)
            gap = $urandom_range(11, 1);
         send_cmd(random_command(), gap);
      end
      req_tvalid <= 1'b0;

      // let the monitor note the last transaction before draining
      @(posedge clock);
      while (shadow.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (shadow.mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
